>>> hw/rtl/bls_pkg.sv
// Shared types and constants of the bytecode loop span scanner.
package bls_pkg;

   localparam int unsigned NUM_OPCODES = 129;
   localparam int unsigned OP_IDX_W    = 8;
   localparam int unsigned OUT_POS_W   = 16;
   localparam int unsigned OUT_OPEN_W  = 5;

   localparam logic [31:0] OP_FOR_START = 32'd11;
   localparam logic [31:0] OP_FOR_END   = 32'd13;

   typedef enum logic [2:0] {
      ST_LOOP_CLOSED = 3'd0,
      ST_END_OK      = 3'd1,
      ST_MISMATCH    = 3'd2,
      ST_UNMATCHED   = 3'd3,
      ST_BAD_OPCODE  = 3'd4,
      ST_CAPACITY    = 3'd5
   } status_type;

   // operand words that follow each opcode
   localparam logic [2:0] OPERAND_COUNT [NUM_OPCODES] = '{
      3'd0, 3'd0, 3'd1, 3'd2, 3'd0, 3'd0, 3'd0, 3'd2,
      3'd1, 3'd0, 3'd0, 3'd3, 3'd1, 3'd0, 3'd0, 3'd0,
      3'd1, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd1,
      3'd1, 3'd1, 3'd1, 3'd1, 3'd0, 3'd1, 3'd0, 3'd1,
      3'd0, 3'd0, 3'd1, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1,
      3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
      3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
      3'd1, 3'd1, 3'd1, 3'd1, 3'd0, 3'd1, 3'd1, 3'd2,
      3'd0, 3'd2, 3'd0, 3'd2, 3'd0, 3'd2, 3'd0, 3'd2,
      3'd0, 3'd2, 3'd2, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
      3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd1,
      3'd2, 3'd1, 3'd2, 3'd1, 3'd1, 3'd1, 3'd0, 3'd1,
      3'd1, 3'd1, 3'd2, 3'd1, 3'd0, 3'd0, 3'd4, 3'd0,
      3'd2, 3'd2, 3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2,
      3'd2, 3'd2, 3'd2, 3'd2, 3'd1, 3'd1, 3'd2, 3'd2,
      3'd1, 3'd1, 3'd1, 3'd2, 3'd0, 3'd0, 3'd1, 3'd0,
      3'd0
   };

endpackage

>>> hw/rtl/bls_if.sv
// Request and response channel interfaces of the loop span scanner.
interface bls_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] code_word;
   logic        last_word;

   modport source (output valid, output code_word, output last_word, input ready);
   modport sink (input valid, input code_word, input last_word, output ready);
endinterface

interface bls_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [15:0] loop_start;
   logic [15:0] loop_span;
   logic [4:0]  open_loops;
   logic        last_result;

   modport source (output valid, output status, output loop_start, output loop_span,
                   output open_loops, output last_result, input ready);
   modport sink (input valid, input status, input loop_start, input loop_span,
                 input open_loops, input last_result, output ready);
endinterface

>>> hw/rtl/bls_stack.sv
// Loop start stack memory: one write port, one registered read port.
module bls_stack #(
   parameter int unsigned DEPTH = 16,
   parameter int unsigned WIDTH = 16,
   parameter int unsigned AW    = 4
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/bytecode_loop_span_scanner_top.sv
// Bytecode loop span scanner: top level.
//
// Usage:
//   req carries one bytecode word per request (code_word, last_word). The first
//   word of a vector is its version; each opcode's operand words are skipped.
//   rsp carries results: one per closed for-loop (status 0), and one final
//   report per vector (end ok, unmatched starts with the open count and the
//   oldest start, or the first error) marked by last_result.
// Throughput: one request per cycle while rsp is not stalled. A request that closes
//   a loop on the last word yields two results, and req.ready drops until both are sent.
// A result is formed in the staged request, together with the stack memory read,
//   and then held in the output register that drives rsp.
// The stack lives in a memory with a registered read port; a pop reads the top
//   entry at the accept edge and the span is formed in the following stage.
// Reset clears all control state; the block then expects a version word.
// When rsp stalls, the output register and one staged request are held, and
//   req.ready drops until the staged request has delivered its results.
module bytecode_loop_span_scanner_top
   import bls_pkg::*;
#(
   parameter int unsigned STACK_DEPTH   = 16,
   parameter int unsigned POSITION_BITS = 16
) (
   input logic   clock,
   input logic   reset,
   bls_req_if.sink   req_bus,
   bls_rsp_if.source rsp_bus
);

   localparam int unsigned PB = POSITION_BITS;
   localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
   localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int unsigned SW = (PB > OUT_POS_W) ? PB : OUT_POS_W;
   localparam int unsigned XW = (PB + 1 > OUT_POS_W) ? PB + 1 : OUT_POS_W;
   localparam int unsigned OW = (CW > OUT_OPEN_W) ? CW : OUT_OPEN_W;

   // scan state
   logic          expect_ff, expect_in;
   logic [PB:0]   wpos_ff, wpos_in;
   logic [2:0]    opl_ff, opl_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          failed_ff, failed_in;
   logic [PB-1:0] bottom_ff, bottom_in;

   // staged request
   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_loop_ff, s1_loop_in;
   logic                  s1_rep_ff, s1_rep_in;
   logic [PB-1:0]         s1_pos_ff;
   status_type            s1_status_ff;
   logic [OUT_POS_W-1:0]  s1_start_ff;
   logic [OUT_OPEN_W-1:0] s1_open_ff;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff;
   logic [OUT_POS_W-1:0]  rsp_start_ff;
   logic [OUT_POS_W-1:0]  rsp_span_ff;
   logic [OUT_OPEN_W-1:0] rsp_open_ff;
   logic                  rsp_last_ff;

   logic                  accept;
   logic                  push, pop, err, over, bad_op;
   status_type            err_status;
   logic                  rep;
   status_type            rep_status;
   logic [OUT_POS_W-1:0]  rep_start;
   logic [OUT_OPEN_W-1:0] rep_open;
   logic [OUT_POS_W-1:0]  pos16;
   logic [31:0]           word;
   logic [2:0]            opl_lookup;
   logic [PB-1:0]         top_start;
   logic [SW-1:0]         span_full;
   logic                  rsp_load, s1_emit, s1_done;

   assign word   = req_bus.code_word;
   assign accept = req_bus.valid && req_bus.ready;
   assign over   = wpos_ff[PB];
   assign bad_op = word >= 32'(NUM_OPCODES);
   assign pos16  = OUT_POS_W'(XW'(wpos_ff));

   assign opl_lookup = bad_op ? 3'd0 : OPERAND_COUNT[word[OP_IDX_W-1:0]];

   always_comb begin
      expect_in  = expect_ff;
      wpos_in    = wpos_ff;
      opl_in     = opl_ff;
      cnt_in     = cnt_ff;
      failed_in  = failed_ff;
      bottom_in  = bottom_ff;
      push       = 1'b0;
      pop        = 1'b0;
      err        = 1'b0;
      err_status = ST_END_OK;
      if (expect_ff) begin
         expect_in = 1'b0;
         wpos_in   = (PB + 1)'(1);
      end else if (!failed_ff) begin
         if (over) begin
            err        = 1'b1;
            err_status = ST_CAPACITY;
         end else if (opl_ff != 3'd0) begin
            opl_in = opl_ff - 3'd1;
         end else if (bad_op) begin
            err        = 1'b1;
            err_status = ST_BAD_OPCODE;
         end else begin
            if (word == OP_FOR_START) begin
               if (cnt_ff >= CW'(STACK_DEPTH)) begin
                  err        = 1'b1;
                  err_status = ST_CAPACITY;
               end else begin
                  push   = 1'b1;
                  cnt_in = cnt_ff + CW'(1);
               end
            end else if (word == OP_FOR_END) begin
               if (cnt_ff == '0) begin
                  err        = 1'b1;
                  err_status = ST_MISMATCH;
               end else begin
                  pop    = 1'b1;
                  cnt_in = cnt_ff - CW'(1);
               end
            end
            if (!err) begin
               opl_in = opl_lookup;
            end
         end
         if (!over) begin
            wpos_in = wpos_ff + (PB + 1)'(1);
         end
         if (err) begin
            failed_in = 1'b1;
         end
      end
      if (push && cnt_ff == '0) begin
         bottom_in = wpos_ff[PB-1:0];
      end

      // final report of the vector, or the first error
      rep        = err || (req_bus.last_word && !failed_in);
      rep_status = ST_END_OK;
      rep_start  = '0;
      rep_open   = '0;
      if (err) begin
         rep_status = err_status;
         rep_start  = pos16;
      end else if (cnt_in != '0) begin
         rep_status = ST_UNMATCHED;
         rep_start  = OUT_POS_W'(SW'(bottom_in));
         rep_open   = OUT_OPEN_W'(OW'(cnt_in));
      end

      // rearm for the next vector
      if (req_bus.last_word) begin
         expect_in = 1'b1;
         wpos_in   = '0;
         opl_in    = 3'd0;
         cnt_in    = '0;
         failed_in = 1'b0;
      end
   end

   bls_stack #(
      .DEPTH (STACK_DEPTH),
      .WIDTH (PB),
      .AW    (AW)
   ) u_stack (
      .clock   (clock),
      .wr_en   (accept && push),
      .wr_addr (cnt_ff[AW-1:0]),
      .wr_data (wpos_ff[PB-1:0]),
      .rd_en   (accept && pop),
      .rd_addr (AW'(cnt_ff - CW'(1))),
      .rd_data (top_start)
   );

   assign span_full = SW'(s1_pos_ff) - SW'(top_start) + SW'(1);

   // staged request hands its results to the output register
   assign rsp_load = !rsp_valid_ff || rsp_bus.ready;
   assign s1_emit  = s1_valid_ff && (s1_loop_ff || s1_rep_ff) && rsp_load;
   assign s1_done  = !s1_valid_ff || (!s1_loop_ff && !s1_rep_ff) ||
                     (rsp_load && !(s1_loop_ff && s1_rep_ff));
   assign req_bus.ready = s1_done;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_loop_in  = s1_loop_ff;
      s1_rep_in   = s1_rep_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_loop_in  = pop;
         s1_rep_in   = rep;
      end else if (s1_done) begin
         s1_valid_in = 1'b0;
         s1_loop_in  = 1'b0;
         s1_rep_in   = 1'b0;
      end else if (s1_emit) begin
         s1_loop_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = s1_emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_ff    <= 1'b1;
         wpos_ff      <= '0;
         opl_ff       <= 3'd0;
         cnt_ff       <= '0;
         failed_ff    <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s1_loop_ff   <= 1'b0;
         s1_rep_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            expect_ff <= expect_in;
            wpos_ff   <= wpos_in;
            opl_ff    <= opl_in;
            cnt_ff    <= cnt_in;
            failed_ff <= failed_in;
         end
         s1_valid_ff  <= s1_valid_in;
         s1_loop_ff   <= s1_loop_in;
         s1_rep_ff    <= s1_rep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         bottom_ff    <= bottom_in;
         s1_pos_ff    <= wpos_ff[PB-1:0];
         s1_status_ff <= rep_status;
         s1_start_ff  <= rep_start;
         s1_open_ff   <= rep_open;
      end
      if (s1_emit) begin
         if (s1_loop_ff) begin
            rsp_status_ff <= ST_LOOP_CLOSED;
            rsp_start_ff  <= OUT_POS_W'(SW'(top_start));
            rsp_span_ff   <= OUT_POS_W'(span_full);
            rsp_open_ff   <= '0;
            rsp_last_ff   <= 1'b0;
         end else begin
            rsp_status_ff <= s1_status_ff;
            rsp_start_ff  <= s1_start_ff;
            rsp_span_ff   <= '0;
            rsp_open_ff   <= s1_open_ff;
            rsp_last_ff   <= 1'b1;
         end
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = rsp_status_ff;
   assign rsp_bus.loop_start  = rsp_start_ff;
   assign rsp_bus.loop_span   = rsp_span_ff;
   assign rsp_bus.open_loops  = rsp_open_ff;
   assign rsp_bus.last_result = rsp_last_ff;

endmodule

>>> test/tb.sv
// Self-checking testbench for the bytecode loop span scanner top level.
module tb
   import bls_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD    = 10;
   localparam int RESET_CYCLES  = 11;
   localparam int LOOP_DEPTH    = 16;
   localparam int LAST_POSITION = 65535;
   localparam int DRAIN_CYCLES  = 8;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int RANDOM_WORDS  = 480;

   // operand words that follow each opcode
   localparam int OPERAND_WORDS [129] = '{
      0, 0, 1, 2, 0, 0, 0, 2, 1, 0, 0, 3, 1, 0, 0, 0,
      1, 0, 0, 0, 1, 1, 1, 1, 1, 1, 1, 1, 0, 1, 0, 1,
      0, 0, 1, 0, 0, 0, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1,
      1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 0, 1, 1, 2,
      0, 2, 0, 2, 0, 2, 0, 2, 0, 2, 2, 0, 0, 0, 0, 0,
      0, 0, 0, 0, 1, 1, 1, 1, 2, 1, 2, 1, 1, 1, 0, 1,
      1, 1, 2, 1, 0, 0, 4, 0, 2, 2, 1, 1, 1, 1, 2, 2,
      2, 2, 2, 2, 1, 1, 2, 2, 1, 1, 1, 2, 0, 0, 1, 0,
      0
   };

   typedef struct packed {
      status_type  status;
      logic [15:0] start_pos;
      logic [15:0] span;
      logic [4:0]  open_count;
      logic        last;
   } loop_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bls_req_if req_bus ();
   bls_rsp_if rsp_bus ();

   bytecode_loop_span_scanner_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // scanner state as predicted
   logic        awaiting_version = 1'b1;
   logic [16:0] next_position = '0;
   int          operands_due = 0;
   logic [15:0] open_starts [LOOP_DEPTH];
   int          loop_depth = 0;
   logic        vector_failed = 1'b0;

   loop_report_type reports_due [$];
   logic [31:0]     vector_words [$];

   int send_idle_pct = 38;
   int recv_idle_pct = 67;
   int send_calm = 0;
   int recv_calm = 0;

   int fail_count = 0;
   int cycle_count = 0;
   int scanned_words = 0;
   int ignored_words = 0;
   int vectors_seen = 0;
   int status_seen [6] = '{default: 0};

   function automatic void post_report(status_type st, logic [15:0] sp, logic [15:0] sn,
                                       logic [4:0] oc, logic lst);
      reports_due.insert(reports_due.size(), '{st, sp, sn, oc, lst});
   endfunction

   function automatic void add_word(logic [31:0] w);
      vector_words.insert(vector_words.size(), w);
   endfunction

   function automatic void rearm_scan();
      awaiting_version = 1'b1;
      next_position    = '0;
      operands_due     = 0;
      loop_depth       = 0;
      vector_failed    = 1'b0;
   endfunction

   // Work out the reports that one accepted request causes.
   function automatic void scan_word(logic [31:0] w, logic last);
      logic [16:0] pos;
      logic [16:0] span;
      if (awaiting_version) begin
         awaiting_version = 1'b0;
         next_position    = 17'd1;
         scanned_words++;
      end else if (!vector_failed) begin
         scanned_words++;
         pos = next_position;
         if (pos > LAST_POSITION) begin
            post_report(ST_CAPACITY, pos[15:0], '0, '0, 1'b1);
            vector_failed = 1'b1;
         end else if (operands_due > 0) begin
            operands_due--;
         end else if (w >= NUM_OPCODES) begin
            post_report(ST_BAD_OPCODE, pos[15:0], '0, '0, 1'b1);
            vector_failed = 1'b1;
         end else begin
            if (w == OP_FOR_START) begin
               if (loop_depth >= LOOP_DEPTH) begin
                  post_report(ST_CAPACITY, pos[15:0], '0, '0, 1'b1);
                  vector_failed = 1'b1;
               end else begin
                  open_starts[loop_depth] = pos[15:0];
                  loop_depth++;
               end
            end else if (w == OP_FOR_END) begin
               if (loop_depth == 0) begin
                  post_report(ST_MISMATCH, pos[15:0], '0, '0, 1'b1);
                  vector_failed = 1'b1;
               end else begin
                  loop_depth--;
                  span = pos - {1'b0, open_starts[loop_depth]} + 17'd1;
                  post_report(ST_LOOP_CLOSED, open_starts[loop_depth], span[15:0], '0, 1'b0);
               end
            end
            if (!vector_failed) operands_due = OPERAND_WORDS[w[7:0]];
         end
         if (next_position <= LAST_POSITION) next_position++;
      end else begin
         ignored_words++;
      end
      if (last) begin
         if (!vector_failed) begin
            if (loop_depth == 0) post_report(ST_END_OK, '0, '0, '0, 1'b1);
            else post_report(ST_UNMATCHED, open_starts[0], '0, 5'(loop_depth), 1'b1);
         end
         rearm_scan();
      end
   endfunction

   // Predict on every accepted request, then check every accepted result.
   always @(posedge clock) begin
      loop_report_type due;
      cycle_count++;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            scan_word(req_bus.code_word, req_bus.last_word);
            if (req_bus.last_word) vectors_seen++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (reports_due.size() == 0) begin
               $error("unexpected result: status %0d start %0d span %0d open %0d last %0d",
                      rsp_bus.status, rsp_bus.loop_start, rsp_bus.loop_span,
                      rsp_bus.open_loops, rsp_bus.last_result);
               fail_count++;
            end else begin
               due = reports_due.pop_front();
               status_seen[due.status]++;
               if (rsp_bus.status !== due.status) begin
                  $error("status: expected %0d, got %0d", due.status, rsp_bus.status);
                  fail_count++;
               end
               if (rsp_bus.loop_start !== due.start_pos) begin
                  $error("loop_start: expected %0d, got %0d", due.start_pos, rsp_bus.loop_start);
                  fail_count++;
               end
               if (rsp_bus.loop_span !== due.span) begin
                  $error("loop_span: expected %0d, got %0d", due.span, rsp_bus.loop_span);
                  fail_count++;
               end
               if (rsp_bus.open_loops !== due.open_count) begin
                  $error("open_loops: expected %0d, got %0d", due.open_count,
                         rsp_bus.open_loops);
                  fail_count++;
               end
               if (rsp_bus.last_result !== due.last) begin
                  $error("last_result: expected %0d, got %0d", due.last, rsp_bus.last_result);
                  fail_count++;
               end
            end
         end
      end
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  reports_due.size());
         $display("bytecode_loop_span_scanner_top test failed");
         $finish;
      end
   end

   // Stall the result channel at random, with calm stretches now and then.
   always @(negedge clock) begin
      if (recv_calm > 0) begin
         recv_calm--;
         rsp_bus.ready <= 1'b1;
      end else if ($urandom_range(99) < 2) begin
         recv_calm = $urandom_range(60, 20);
         rsp_bus.ready <= 1'b1;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_word(logic [31:0] w, logic last);
      if (send_calm > 0) send_calm--;
      else if ($urandom_range(99) < 2) send_calm = $urandom_range(60, 20);
      while (send_calm == 0 && $urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.code_word <= w;
      req_bus.last_word <= last;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   task automatic send_vector();
      for (int i = 0; i < vector_words.size(); i++)
         send_word(vector_words[i], i == vector_words.size() - 1);
   endtask

   function automatic logic [31:0] random_operand();
      return ($urandom_range(3) == 0) ? 32'($urandom_range(140)) : 32'($urandom);
   endfunction

   function automatic void push_loop_start();
      add_word(OP_FOR_START);
      repeat (OPERAND_WORDS[OP_FOR_START]) add_word(random_operand());
   endfunction

   task automatic test_vector_shapes();
      // version word only
      vector_words = '{32'h7FFF_FFFF};
      send_vector();
      // loop end with no loop open, on the last word
      vector_words = '{32'h8000_0000, OP_FOR_END};
      send_vector();
      // last word closes a loop: loop report, then end report
      vector_words = '{32'h0000_0000, OP_FOR_START, 32'hFFFF_FFFF, 32'h0, 32'h5A5A_A5A5,
                       OP_FOR_END};
      send_vector();
      // negative opcode, then ignore the rest and rearm quietly
      vector_words = '{32'h1234_5678, 32'h8000_0000, OP_FOR_START, OP_FOR_END};
      send_vector();
      // first opcode past the table, on the last word
      vector_words = '{32'hFFFF_FFFF, 32'd129};
      send_vector();
      // highest valid opcode, then a loop opened by the last word
      vector_words = '{32'hA5A5_5A5A, 32'd128, OP_FOR_START};
      send_vector();
      // vector ends while operand words are still due
      vector_words = '{32'h0F0F_F0F0, 32'd102, 32'hFFFF_FFFF, 32'h0};
      send_vector();
   endtask

   task automatic test_stack_full();
      // every stack entry in use at the end
      vector_words = '{$urandom};
      repeat (LOOP_DEPTH) push_loop_start();
      send_vector();
      // every entry used, then all closed innermost first
      vector_words = '{$urandom};
      repeat (LOOP_DEPTH) push_loop_start();
      repeat (LOOP_DEPTH) add_word(OP_FOR_END);
      send_vector();
      // one start too many
      vector_words = '{$urandom};
      repeat (LOOP_DEPTH + 1) push_loop_start();
      add_word(OP_FOR_END);
      send_vector();
   endtask

   task automatic build_random_vector();
      int kind;
      int length;
      int depth;
      int op;
      int start_pct;
      int headroom;
      vector_words = '{$urandom};
      kind = $urandom_range(99);
      if (kind < 12) begin
         repeat ($urandom_range(8)) add_word(random_operand());
         return;
      end
      if (kind >= 38 && kind < 45) begin
         length    = $urandom_range(120, 80);
         start_pct = 60;
         headroom  = 1;
      end else begin
         length    = ($urandom_range(19) == 0) ? $urandom_range(120, 60) : $urandom_range(30);
         start_pct = 28;
         headroom  = 0;
      end
      depth = 0;
      while (vector_words.size() < length) begin
         op = $urandom_range(99);
         if (depth < LOOP_DEPTH + headroom && op < start_pct) begin
            push_loop_start();
            depth++;
         end else if (depth > 0 && op < start_pct + 22) begin
            add_word(OP_FOR_END);
            depth--;
         end else begin
            do op = $urandom_range(128); while (op == OP_FOR_START || op == OP_FOR_END);
            add_word(op);
            repeat (OPERAND_WORDS[op]) add_word(random_operand());
         end
      end
      if ($urandom_range(9) < 7) repeat (depth) add_word(OP_FOR_END);
      if (kind < 30) begin
         // plant one fault somewhere after the version
         case ($urandom_range(3))
            0: op = $urandom | 32'h8000_0000;
            1: op = $urandom_range(255, NUM_OPCODES);
            2: op = OP_FOR_END;
            default: op = $urandom;
         endcase
         vector_words.insert($urandom_range(vector_words.size(), 1), op);
      end else if (kind < 38) begin
         // cut the vector short, possibly inside operands
         length = $urandom_range(vector_words.size(), 1);
         while (vector_words.size() > length) vector_words.delete(vector_words.size() - 1);
      end
   endtask

   task automatic test_random_vectors(int target);
      int first;
      first = scanned_words;
      while (scanned_words - first < target) begin
         build_random_vector();
         send_vector();
      end
   endtask

   initial begin
      req_bus.valid     = 1'b0;
      req_bus.code_word = '0;
      req_bus.last_word = 1'b0;
      rsp_bus.ready     = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_vector_shapes();
      test_stack_full();
      test_random_vectors(RANDOM_WORDS);
      send_idle_pct = 67;
      recv_idle_pct = 38;
      test_random_vectors(RANDOM_WORDS);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_vectors(RANDOM_WORDS);
      req_bus.valid <= 1'b0;

      while (reports_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("scanned %0d vectors: %0d words checked, %0d words skipped after a fault",
               vectors_seen, scanned_words, ignored_words);
      $display("results: %0d closed, %0d end ok, %0d mismatch, %0d unmatched,",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
      $display("         %0d bad op, %0d over capacity", status_seen[4], status_seen[5]);
      if (fail_count == 0) begin
         $display("bytecode_loop_span_scanner_top test passed");
      end else begin
         $display("bytecode_loop_span_scanner_top test failed");
      end
      $finish;
   end

endmodule

>>> bytecode_loop_span_scanner_top.f
hw/rtl/bls_pkg.sv
hw/rtl/bls_if.sv
hw/rtl/bls_stack.sv
hw/rtl/bytecode_loop_span_scanner_top.sv
test/tb.sv
